@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the grid walker checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PGW_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pgw assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PGW_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pgw assertion failed");

`endif

@@ hw/rtl/pgw_pkg.sv @@
// ----------------------------------------------------------------------------
// pgw_pkg
// Types, codes and constants shared by the grid walker modules.
// ----------------------------------------------------------------------------
package pgw_pkg;

  // Default grid size.
  localparam int MaxRowsDef = 64;
  localparam int MaxColsDef = 64;

  // Neighborhood: radius one, eight slots.
  localparam int NbSlots = 8;
  localparam logic signed [1:0] NB_DROW [NbSlots] = '{-2'sd1, -2'sd1, -2'sd1, 2'sd0,
                                                      2'sd0, 2'sd1, 2'sd1, 2'sd1};
  localparam logic signed [1:0] NB_DCOL [NbSlots] = '{-2'sd1, 2'sd0, 2'sd1, -2'sd1,
                                                      2'sd1, -2'sd1, 2'sd0, 2'sd1};

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // Cell codes.
  localparam logic [1:0] CODE_FREE    = 2'd0;
  localparam logic [1:0] CODE_WALL    = 2'd1;
  localparam logic [1:0] CODE_VISITED = 2'd2;
  localparam logic [1:0] CODE_ROBOT   = 2'd3;

  // Memory word: cell code over pheromone level.
  localparam int WordW = 19;

  // Register indexes.
  localparam logic [2:0] REG_ROWS = 3'd0;
  localparam logic [2:0] REG_COLS = 3'd1;
  localparam logic [2:0] REG_DEP  = 3'd2;
  localparam logic [2:0] REG_OWN  = 3'd3;
  localparam logic [2:0] REG_EVAP = 3'd4;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_PLACE = 2'd1,
    FUNC_MOVE  = 2'd2,
    FUNC_EVAP  = 2'd3
  } pgw_func_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REJECT  = 2'd1,
    ST_NO_FREE = 2'd2
  } pgw_status_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_PL_RD, S_PL_CHK,
    S_NB_ISSUE, S_NB_DATA, S_NB_WR, S_OWN_RD, S_OWN_DATA, S_OWN_WR,
    S_TGT, S_ROUL, S_MV_OLD, S_MV_RD, S_MV_WR,
    S_EV_RD, S_EV_DAT, S_EV_WR, S_FIN, S_EMIT
  } pgw_state_e;

  typedef struct packed {
    logic [6:0]  rows_in_use;
    logic [6:0]  cols_in_use;
    logic [16:0] deposit_gain;
    logic [16:0] own_gain;
    logic [16:0] evaporation_rate;
  } pgw_cfg_t;

  // Saturate a Q1.16 value at one.
  function automatic logic [16:0] clamp_one(input logic [16:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

endpackage

@@ hw/rtl/pgw_ram.sv @@
// ----------------------------------------------------------------------------
// pgw_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pgw_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/pgw_seq.sv @@
// ----------------------------------------------------------------------------
// pgw_seq
// Operation sequencer: read-modify-write of the grid memory for every item but load, which only writes.
// ----------------------------------------------------------------------------
module pgw_seq import pgw_pkg::*; #(
  parameter int MaxRows = MaxRowsDef,
  parameter int MaxCols = MaxColsDef,
  localparam int Depth  = MaxRows * MaxCols,
  localparam int AW     = $clog2(Depth)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pgw_cfg_t           cfg_i,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func_i,
  input  logic [5:0]         row_i,
  input  logic [5:0]         col_i,
  input  logic [1:0]         cell_code_i,
  input  logic [15:0]        random_fraction_i,
  output logic               done_o,
  output logic [5:0]         robot_row_o,
  output logic [5:0]         robot_col_o,
  output logic [16:0]        pheromone_here_o,
  output logic [1:0]         status_o,
  output logic               ram_we_o,
  output logic [AW-1:0]      ram_waddr_o,
  output logic [WordW-1:0]   ram_wdata_o,
  output logic [AW-1:0]      ram_raddr_o,
  input  logic [WordW-1:0]   ram_rdata_i
);

  localparam int RW = $clog2(MaxRows);
  localparam int CW = $clog2(MaxCols);

  pgw_state_e state_q, state_d;

  logic [1:0]    func_q, code_q;
  logic [5:0]    row_q, col_q;
  logic [15:0]   rnd_q;
  logic [RW-1:0] robot_r_q, er_q;
  logic [CW-1:0] robot_c_q, ec_q;
  logic [AW-1:0] clr_q;
  logic [2:0]    k_q, pick_q;
  logic [3:0]    n_q;
  logic [19:0]   total_q, acc_q;
  logic [35:0]   target_q;
  logic [16:0]   pc_q, own_p_q;
  logic [33:0]   prod_q;
  logic [1:0]    mcode_q;
  pgw_status_e   status_q;
  logic [16:0]   w_q  [NbSlots];
  logic [RW-1:0] nr_q [NbSlots];
  logic [CW-1:0] nc_q [NbSlots];
  logic          done_q;
  logic [5:0]    res_row_q, res_col_q;
  logic [16:0]   res_p_q;
  logic [1:0]    res_st_q;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                               input logic [CW-1:0] c);
    return AW'(r) * AW'(MaxCols) + AW'(c);
  endfunction

  // Bounds in use.
  logic [RW:0] eff_rows;
  logic [CW:0] eff_cols;
  assign eff_rows = (32'(cfg_i.rows_in_use) < MaxRows) ? (RW+1)'(cfg_i.rows_in_use)
                                                       : (RW+1)'(MaxRows);
  assign eff_cols = (32'(cfg_i.cols_in_use) < MaxCols) ? (CW+1)'(cfg_i.cols_in_use)
                                                       : (CW+1)'(MaxCols);

  // Target cell of load and place.
  logic          in_area;
  logic [AW-1:0] in_addr, here_addr, nb_addr, ev_addr;
  assign in_area   = (32'(row_q) < 32'(eff_rows)) && (32'(col_q) < 32'(eff_cols));
  assign in_addr   = cell_addr(RW'(row_q), CW'(col_q));
  assign here_addr = cell_addr(robot_r_q, robot_c_q);
  assign ev_addr   = cell_addr(er_q, ec_q);

  // Neighbor of the current slot.
  logic signed [RW+1:0] nrs;
  logic signed [CW+1:0] ncs;
  logic                 nb_in;
  logic [1:0]           drow, dcol;
  assign drow  = NB_DROW[k_q];
  assign dcol  = NB_DCOL[k_q];
  assign nrs   = $signed({2'b00, robot_r_q}) + $signed({{RW{drow[1]}}, drow});
  assign ncs   = $signed({2'b00, robot_c_q}) + $signed({{CW{dcol[1]}}, dcol});
  assign nb_in = !nrs[RW+1] && !ncs[CW+1] &&
                 (nrs < $signed({1'b0, eff_rows})) && (ncs < $signed({1'b0, eff_cols}));
  assign nb_addr = cell_addr(nrs[RW-1:0], ncs[CW-1:0]);

  // Memory read fields.
  logic [1:0]  rd_code;
  logic [16:0] rd_p, rd_pc;
  assign rd_code = ram_rdata_i[WordW-1:17];
  assign rd_p    = ram_rdata_i[16:0];
  assign rd_pc   = clamp_one(rd_p);

  // Shared multiplier of the update step.
  logic [16:0] mul_a, mul_b;
  logic [33:0] prod;
  always_comb begin
    mul_a = ONE_Q16 - rd_pc;
    mul_b = clamp_one(cfg_i.deposit_gain);
    if (state_q == S_OWN_DATA) begin
      mul_b = clamp_one(cfg_i.own_gain);
    end else if (state_q == S_EV_DAT) begin
      mul_a = rd_pc;
      mul_b = clamp_one(cfg_i.evaporation_rate);
    end
  end
  assign prod = mul_a * mul_b;

  logic [16:0] dep_new, evap_new;
  assign dep_new  = pc_q + prod_q[32:16];
  assign evap_new = pc_q - prod_q[32:16];

  // Roulette step.
  logic [19:0] acc_next;
  logic        hit;
  assign acc_next = acc_q + 20'(w_q[k_q]);
  assign hit      = {acc_next, 16'h0000} >= target_q;

  logic k_last, ev_last_c, ev_last_r, ev_empty, nb_adv;
  assign k_last    = (k_q == 3'(NbSlots - 1));
  assign ev_last_c = ({1'b0, ec_q} == eff_cols - 1'b1);
  assign ev_last_r = ({1'b0, er_q} == eff_rows - 1'b1);
  assign ev_empty  = (eff_rows == '0) || (eff_cols == '0);
  assign nb_adv    = ((state_q == S_NB_ISSUE) && !nb_in) ||
                     ((state_q == S_NB_DATA) && (rd_code == CODE_WALL)) ||
                     (state_q == S_NB_WR);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and memory control.
  always_comb begin
    state_d     = state_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = here_addr;
    ram_wdata_o = '0;
    ram_raddr_o = here_addr;
    unique case (state_q)
      S_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = {CODE_FREE, 17'h00000};
        if (clr_q == AW'(Depth - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          unique case (pgw_func_e'(func_i))
            FUNC_LOAD:  state_d = S_LOAD;
            FUNC_PLACE: state_d = S_PL_RD;
            FUNC_MOVE:  state_d = S_NB_ISSUE;
            FUNC_EVAP:  state_d = S_EV_RD;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        ram_we_o    = in_area;
        ram_waddr_o = in_addr;
        ram_wdata_o = {code_q, 17'h00000};
        state_d     = S_FIN;
      end
      S_PL_RD: begin
        ram_raddr_o = in_addr;
        state_d     = in_area ? S_PL_CHK : S_FIN;
      end
      S_PL_CHK: begin
        ram_we_o    = (rd_code != CODE_WALL);
        ram_waddr_o = in_addr;
        ram_wdata_o = {CODE_ROBOT, rd_p};
        state_d     = S_FIN;
      end
      S_NB_ISSUE: begin
        ram_raddr_o = nb_addr;
        if (nb_in) state_d = S_NB_DATA;
        else if (k_last) state_d = S_OWN_RD;
      end
      S_NB_DATA: begin
        if (rd_code == CODE_WALL) state_d = k_last ? S_OWN_RD : S_NB_ISSUE;
        else state_d = S_NB_WR;
      end
      S_NB_WR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = nb_addr;
        ram_wdata_o = {mcode_q, dep_new};
        state_d     = k_last ? S_OWN_RD : S_NB_ISSUE;
      end
      S_OWN_RD:   state_d = S_OWN_DATA;
      S_OWN_DATA: state_d = S_OWN_WR;
      S_OWN_WR: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = {mcode_q, dep_new};
        state_d     = (n_q == '0) ? S_FIN : S_TGT;
      end
      S_TGT:  state_d = (total_q == '0) ? S_MV_OLD : S_ROUL;
      S_ROUL: if (hit) state_d = S_MV_OLD;
      S_MV_OLD: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = {CODE_VISITED, own_p_q};
        state_d     = S_MV_RD;
      end
      S_MV_RD: state_d = S_MV_WR;
      S_MV_WR: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = {CODE_ROBOT, rd_p};
        state_d     = S_FIN;
      end
      S_EV_RD: begin
        ram_raddr_o = ev_addr;
        state_d     = ev_empty ? S_FIN : S_EV_DAT;
      end
      S_EV_DAT: state_d = S_EV_WR;
      S_EV_WR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = ev_addr;
        ram_wdata_o = {mcode_q, evap_new};
        state_d     = (ev_last_c && ev_last_r) ? S_FIN : S_EV_RD;
      end
      S_FIN:  state_d = S_EMIT;
      S_EMIT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control counters, robot position and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      k_q       <= '0;
      n_q       <= '0;
      robot_r_q <= '0;
      robot_c_q <= '0;
      er_q      <= '0;
      ec_q      <= '0;
      done_q    <= 1'b0;
      status_q  <= ST_OK;
    end else begin
      done_q <= (state_q == S_EMIT);
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == S_IDLE && start) begin
        k_q      <= '0;
        n_q      <= '0;
        er_q     <= '0;
        ec_q     <= '0;
        status_q <= ST_OK;
      end
      if (nb_adv) k_q <= k_q + 1'b1;
      if (state_q == S_NB_WR) n_q <= n_q + 1'b1;
      if (state_q == S_PL_RD && !in_area) status_q <= ST_REJECT;
      if (state_q == S_PL_CHK) begin
        if (rd_code == CODE_WALL) begin
          status_q <= ST_REJECT;
        end else begin
          robot_r_q <= RW'(row_q);
          robot_c_q <= CW'(col_q);
        end
      end
      if (state_q == S_OWN_WR) begin
        k_q <= '0;
        if (n_q == '0) status_q <= ST_NO_FREE;
      end
      if (state_q == S_ROUL) k_q <= k_q + 1'b1;
      if (state_q == S_MV_OLD) begin
        robot_r_q <= nr_q[pick_q];
        robot_c_q <= nc_q[pick_q];
      end
      if (state_q == S_EV_WR) begin
        if (ev_last_c) begin
          ec_q <= '0;
          er_q <= er_q + 1'b1;
        end else begin
          ec_q <= ec_q + 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      func_q  <= func_i;
      row_q   <= row_i;
      col_q   <= col_i;
      code_q  <= cell_code_i;
      rnd_q   <= random_fraction_i;
      total_q <= '0;
    end
    if (state_q == S_NB_DATA || state_q == S_OWN_DATA || state_q == S_EV_DAT) begin
      pc_q    <= rd_pc;
      prod_q  <= prod;
      mcode_q <= rd_code;
    end
    if (state_q == S_NB_WR) begin
      w_q[n_q[2:0]]  <= ONE_Q16 - dep_new;
      nr_q[n_q[2:0]] <= nrs[RW-1:0];
      nc_q[n_q[2:0]] <= ncs[CW-1:0];
      total_q        <= total_q + 20'(ONE_Q16 - dep_new);
    end
    if (state_q == S_OWN_WR) begin
      own_p_q <= dep_new;
      pick_q  <= 3'(n_q - 1'b1);
      acc_q   <= '0;
    end
    if (state_q == S_TGT) target_q <= 36'(rnd_q) * 36'(total_q);
    if (state_q == S_ROUL) begin
      acc_q <= acc_next;
      if (hit) pick_q <= k_q;
    end
    if (state_q == S_EMIT) begin
      res_row_q <= 6'(robot_r_q);
      res_col_q <= 6'(robot_c_q);
      res_p_q   <= rd_p;
      res_st_q  <= (pgw_func_e'(func_q) == FUNC_LOAD || pgw_func_e'(func_q) == FUNC_EVAP)
                   ? ST_OK : status_q;
    end
  end

  assign busy             = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign robot_row_o      = res_row_q;
  assign robot_col_o      = res_col_q;
  assign pheromone_here_o = res_p_q;
  assign status_o         = res_st_q;

endmodule

@@ hw/rtl/pheromone_grid_walker_unit.sv @@
// ----------------------------------------------------------------------------
// pheromone_grid_walker_unit
// Grid map walker that deposits, evaporates and steers by pheromone.
// ----------------------------------------------------------------------------
// Items are taken with start while busy is low; each item yields one result,
// shown for one cycle with done_o, and the receiver cannot stall it. All grid
// state sits in one memory (cell code and pheromone per cell), so every access
// goes through its single read and write port and items run one at a time. A
// move reads and updates each free neighbor, only reads each wall, skips each
// slot off the in-use area and updates its own cell, then picks a free neighbor
// by roulette; evaporate reads and writes every in-use cell. After reset a
// clearing pass over all MaxRows*MaxCols cells holds busy high; configuration
// writes are taken at any time.
module pheromone_grid_walker_unit import pgw_pkg::*; #(
  parameter int MaxRows = MaxRowsDef,
  parameter int MaxCols = MaxColsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [5:0]  row_i,
  input  logic [5:0]  col_i,
  input  logic [1:0]  cell_code_i,
  input  logic [15:0] random_fraction_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  output logic        done_o,
  output logic [5:0]  robot_row_o,
  output logic [5:0]  robot_col_o,
  output logic [16:0] pheromone_here_o,
  output logic [1:0]  status_o
);

  localparam int Depth = MaxRows * MaxCols;
  localparam int AW    = $clog2(Depth);

  pgw_cfg_t cfg_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows_in_use      <= 7'd64;
      cfg_q.cols_in_use      <= 7'd64;
      cfg_q.deposit_gain     <= 17'd14300;
      cfg_q.own_gain         <= 17'd42598;
      cfg_q.evaporation_rate <= 17'd6554;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ROWS: cfg_q.rows_in_use      <= cfg_data_i[6:0];
        REG_COLS: cfg_q.cols_in_use      <= cfg_data_i[6:0];
        REG_DEP:  cfg_q.deposit_gain     <= cfg_data_i;
        REG_OWN:  cfg_q.own_gain         <= cfg_data_i;
        REG_EVAP: cfg_q.evaporation_rate <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [WordW-1:0] ram_wdata, ram_rdata;

  // Grid memory.
  pgw_ram #(.Width(WordW), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Operation sequencer.
  pgw_seq #(.MaxRows(MaxRows), .MaxCols(MaxCols)) u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .start             (start),
    .busy              (busy),
    .func_i            (func_i),
    .row_i             (row_i),
    .col_i             (col_i),
    .cell_code_i       (cell_code_i),
    .random_fraction_i (random_fraction_i),
    .done_o            (done_o),
    .robot_row_o       (robot_row_o),
    .robot_col_o       (robot_col_o),
    .pheromone_here_o  (pheromone_here_o),
    .status_o          (status_o),
    .ram_we_o          (ram_we),
    .ram_waddr_o       (ram_waddr),
    .ram_wdata_o       (ram_wdata),
    .ram_raddr_o       (ram_raddr),
    .ram_rdata_i       (ram_rdata)
  );

endmodule

@@ hw/rtl/pgw_checker.sv @@
// ----------------------------------------------------------------------------
// pgw_checker
// Port-level checks of the grid walker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pgw_checker import pgw_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [1:0] status_o
);

  // An accepted item keeps the block busy in the next cycle.
  `PGW_ASSERT_NXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
  // A result follows an item that was in work.
  `PGW_ASSERT_IMP(a_done_after_busy, clk_i, rst_ni, done_o, $past(busy))
  // Results never come in adjacent cycles.
  `PGW_ASSERT_NXT(a_done_single, clk_i, rst_ni, done_o, !done_o)
  // The status code is one of the defined codes.
  `PGW_ASSERT_IMP(a_status_code, clk_i, rst_ni, done_o,
                  status_o == ST_OK || status_o == ST_REJECT || status_o == ST_NO_FREE)

endmodule

bind pheromone_grid_walker_unit pgw_checker u_pgw_checker (.*);

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pheromone grid walker unit.
// ----------------------------------------------------------------------------
// The cells that the run can read are loaded first: the top four rows, the
// left four columns, the upper-left 16 by 16 block and the far corner. The
// random phases keep their in-use area inside them, so no cell is read before
// it was written. A short directed run covers the corner cells, a rejected
// placement, a robot boxed in by walls, a zero roulette total and an evaporate
// sweep. Random items then run under a series of register settings, the
// extremes among them. A behavioral copy of the walker predicts every result,
// and the monitor compares each done_o cycle with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import pgw_pkg::*;

  localparam int GridDim = 64;
  localparam int Cells = GridDim * GridDim;
  localparam int One = 65536;

  typedef struct {
    pgw_func_e   func;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [1:0]  code;
    logic [15:0] rnd;
  } walk_item_t;

  typedef struct {
    logic [5:0]  row;
    logic [5:0]  col;
    logic [16:0] pher;
    logic [1:0]  status;
  } walk_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  func_i = '0;
  logic [5:0]  row_i = '0;
  logic [5:0]  col_i = '0;
  logic [1:0]  cell_code_i = '0;
  logic [15:0] random_fraction_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [16:0] cfg_data_i = '0;
  logic        done_o;
  logic [5:0]  robot_row_o;
  logic [5:0]  robot_col_o;
  logic [16:0] pheromone_here_o;
  logic [1:0]  status_o;

  pheromone_grid_walker_unit uut (.*);

  // Clock with a 10 unit period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the grid, the robot and the registers.
  logic [1:0]  map_code [Cells];
  int unsigned map_pher [Cells];
  int unsigned bot_row, bot_col;
  int unsigned rows_reg = 64, cols_reg = 64;
  int unsigned dep_reg = 14300, own_reg = 42598, evap_reg = 6554;

  walk_item_t   pending_items[$];
  walk_result_t expected_results[$];
  walk_item_t   cur_item;
  bit           item_active = 1'b0;
  bit           item_taken = 1'b0;
  int           gap_cycles = 0;
  bit           failed = 1'b0;

  function automatic int unsigned sat_one(int unsigned v);
    return (v > One) ? One : v;
  endfunction

  function automatic int unsigned rows_eff();
    return (rows_reg < GridDim) ? rows_reg : GridDim;
  endfunction

  function automatic int unsigned cols_eff();
    return (cols_reg < GridDim) ? cols_reg : GridDim;
  endfunction

  function automatic int unsigned add_deposit(int unsigned p, int unsigned gain);
    longint unsigned headroom;
    int unsigned pc;
    pc = sat_one(p);
    headroom = longint'(One - pc) * sat_one(gain);
    return pc + int'(headroom >> 16);
  endfunction

  // Deposit on the neighbors and the own cell, then pick by roulette.
  function automatic pgw_status_e step_robot(int unsigned rnd);
    int unsigned nb_row [8], nb_col [8], wt [8];
    int unsigned n, pick, here, idx;
    longint unsigned total, acc, target;
    int r, c;
    n = 0;
    total = 0;
    acc = 0;
    here = bot_row * GridDim + bot_col;
    for (int di = -1; di <= 1; di++) begin
      for (int dj = -1; dj <= 1; dj++) begin
        r = int'(bot_row) + di;
        c = int'(bot_col) + dj;
        if (di == 0 && dj == 0) continue;
        if (r < 0 || c < 0 || r >= int'(rows_eff()) || c >= int'(cols_eff())) continue;
        idx = r * GridDim + c;
        if (map_code[idx] == CODE_WALL || n >= 8) continue;
        map_pher[idx] = add_deposit(map_pher[idx], dep_reg);
        nb_row[n] = r;
        nb_col[n] = c;
        wt[n] = One - map_pher[idx];
        total += wt[n];
        n++;
      end
    end
    map_pher[here] = add_deposit(map_pher[here], own_reg);
    if (n == 0) return ST_NO_FREE;
    // A zero total falls through to the last neighbor.
    pick = n - 1;
    if (total != 0) begin
      target = longint'(rnd) * total;
      for (int k = 0; k < n; k++) begin
        acc += wt[k];
        if (acc * One >= target) begin
          pick = k;
          break;
        end
      end
    end
    map_code[here] = CODE_VISITED;
    bot_row = nb_row[pick];
    bot_col = nb_col[pick];
    map_code[bot_row * GridDim + bot_col] = CODE_ROBOT;
    return ST_OK;
  endfunction

  // Apply one item to the shadow grid and return what the block must show.
  function automatic walk_result_t predict_walk(walk_item_t it);
    walk_result_t res;
    pgw_status_e st;
    int unsigned idx, rate, p;
    bit in_area;
    st = ST_OK;
    in_area = (it.row < rows_eff()) && (it.col < cols_eff());
    idx = it.row * GridDim + it.col;
    case (it.func)
      FUNC_LOAD: begin
        if (in_area) begin
          map_code[idx] = it.code;
          map_pher[idx] = 0;
        end
      end
      FUNC_PLACE: begin
        if (!in_area || map_code[idx] == CODE_WALL) begin
          st = ST_REJECT;
        end else begin
          bot_row = it.row;
          bot_col = it.col;
          map_code[idx] = CODE_ROBOT;
        end
      end
      FUNC_MOVE: st = step_robot(it.rnd);
      default: begin
        rate = sat_one(evap_reg);
        for (int r = 0; r < int'(rows_eff()); r++) begin
          for (int c = 0; c < int'(cols_eff()); c++) begin
            p = sat_one(map_pher[r * GridDim + c]);
            map_pher[r * GridDim + c] = p - int'((longint'(p) * rate) >> 16);
          end
        end
      end
    endcase
    res.row = bot_row[5:0];
    res.col = bot_col[5:0];
    res.pher = map_pher[bot_row * GridDim + bot_col][16:0];
    res.status = st;
    return res;
  endfunction

  // Item driver: present the next queued item after a random gap.
  always @(negedge clk_i) begin
    logic start_n;
    start_n = start;
    if (rst_ni) begin
      if (item_active && item_taken) begin
        item_active = 1'b0;
        item_taken = 1'b0;
        start_n = 1'b0;
      end
      if (!item_active) begin
        if (gap_cycles > 0) begin
          gap_cycles--;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          func_i <= cur_item.func;
          row_i <= cur_item.row;
          col_i <= cur_item.col;
          cell_code_i <= cur_item.code;
          random_fraction_i <= cur_item.rnd;
          start_n = 1'b1;
          item_active = 1'b1;
          gap_cycles = $urandom_range(0, 3);
        end
      end
    end
    start <= start_n;
  end

  // Monitor: check results and record accepted items.
  always @(posedge clk_i) begin
    walk_result_t exp_res;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: row %0d col %0d pher %0d status %0d",
                   $time, robot_row_o, robot_col_o, pheromone_here_o, status_o);
          failed = 1'b1;
        end else begin
          exp_res = expected_results.pop_front();
          if (robot_row_o !== exp_res.row) begin
            $display("%0t: robot_row expected %0d actual %0d", $time, exp_res.row,
                     robot_row_o);
            failed = 1'b1;
          end
          if (robot_col_o !== exp_res.col) begin
            $display("%0t: robot_col expected %0d actual %0d", $time, exp_res.col,
                     robot_col_o);
            failed = 1'b1;
          end
          if (pheromone_here_o !== exp_res.pher) begin
            $display("%0t: pheromone_here expected %0d actual %0d", $time, exp_res.pher,
                     pheromone_here_o);
            failed = 1'b1;
          end
          if (status_o !== exp_res.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_res.status,
                     status_o);
            failed = 1'b1;
          end
        end
      end
      if (start && !busy && item_active && !item_taken) begin
        expected_results.push_back(predict_walk(cur_item));
        item_taken = 1'b1;
      end
    end
  end

  task automatic queue_item(pgw_func_e f, int r, int c, int code, int rnd);
    walk_item_t it;
    it.func = f;
    it.row = 6'(r);
    it.col = 6'(c);
    it.code = 2'(code);
    it.rnd = 16'(rnd);
    pending_items.push_back(it);
  endtask

  // Wait until every queued item has been answered and the block is quiet.
  task automatic drain();
    wait (pending_items.size() == 0 && !item_active && expected_results.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] index, int unsigned value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value[16:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      REG_ROWS: rows_reg = value & 7'h7f;
      REG_COLS: cols_reg = value & 7'h7f;
      REG_DEP:  dep_reg = value & 17'h1ffff;
      REG_OWN:  own_reg = value & 17'h1ffff;
      default:  evap_reg = value & 17'h1ffff;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(int unsigned r, int unsigned c, int unsigned dep,
                          int unsigned own, int unsigned evap);
    write_reg(REG_ROWS, r);
    write_reg(REG_COLS, c);
    write_reg(REG_DEP, dep);
    write_reg(REG_OWN, own);
    write_reg(REG_EVAP, evap);
  endtask

  // Random items, moves most often and mostly near the in-use area, then drain.
  task automatic random_phase(int count);
    int unsigned span_r, span_c, area, sel;
    int r, c;
    pgw_func_e f;
    span_r = (rows_eff() + 2 > GridDim) ? GridDim : rows_eff() + 2;
    span_c = (cols_eff() + 2 > GridDim) ? GridDim : cols_eff() + 2;
    area = rows_eff() * cols_eff();
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 20) f = FUNC_LOAD;
      else if (sel < 38) f = FUNC_PLACE;
      else if (sel < 86) f = FUNC_MOVE;
      else f = FUNC_EVAP;
      // Full-grid sweeps are slow, so they stay rare on large areas.
      if (f == FUNC_EVAP && area > 256 && $urandom_range(0, 19) != 0) f = FUNC_MOVE;
      if ($urandom_range(0, 7) == 0) begin
        r = $urandom_range(0, 63);
        c = $urandom_range(0, 63);
      end else begin
        r = $urandom_range(0, span_r - 1);
        c = $urandom_range(0, span_c - 1);
      end
      sel = $urandom_range(0, 9);
      queue_item(f, r, c, (sel < 6) ? CODE_FREE : (sel < 8) ? CODE_WALL : $urandom_range(0, 3),
                 $urandom_range(0, 65535));
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < Cells; i++) begin
      map_code[i] = CODE_FREE;
      map_pher[i] = 0;
    end
    bot_row = 0;
    bot_col = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Write every cell that a later item can read; a few walls scattered in.
    for (int r = 0; r < GridDim; r++) begin
      for (int c = 0; c < GridDim; c++) begin
        int code;
        code = ($urandom_range(0, 9) < 8) ? CODE_FREE : $urandom_range(0, 3);
        if (r < 4 || c < 4 || (r < 16 && c < 16) ||
            (r >= GridDim - 2 && c >= GridDim - 2)) begin
          queue_item(FUNC_LOAD, r, c, code, $urandom_range(0, 65535));
        end
      end
    end
    drain();

    // Directed: corners, extreme draws, rejection, boxed-in robot, evaporate.
    queue_item(FUNC_LOAD, 0, 0, CODE_FREE, 0);
    queue_item(FUNC_PLACE, 0, 0, 0, 0);
    queue_item(FUNC_MOVE, 0, 0, 0, 0);
    queue_item(FUNC_MOVE, 0, 0, 0, 65535);
    queue_item(FUNC_LOAD, 63, 63, CODE_VISITED, 0);
    queue_item(FUNC_PLACE, 63, 63, 0, 0);
    queue_item(FUNC_MOVE, 63, 63, 3, 32768);
    queue_item(FUNC_LOAD, 10, 10, CODE_WALL, 0);
    queue_item(FUNC_PLACE, 10, 10, 0, 0);
    queue_item(FUNC_LOAD, 20, 20, CODE_FREE, 0);
    for (int dr = -1; dr <= 1; dr++)
      for (int dc = -1; dc <= 1; dc++)
        if (dr != 0 || dc != 0) queue_item(FUNC_LOAD, 20 + dr, 20 + dc, CODE_WALL, 0);
    queue_item(FUNC_PLACE, 20, 20, 0, 0);
    queue_item(FUNC_MOVE, 0, 0, 0, 12345);
    queue_item(FUNC_LOAD, 5, 5, CODE_ROBOT, 0);
    queue_item(FUNC_EVAP, 0, 0, 0, 0);
    drain();

    // A full deposit gain drives every neighbor to one: zero roulette total.
    set_regs(64, 64, 65536, 65536, 65536);
    queue_item(FUNC_PLACE, 8, 8, 0, 0);
    queue_item(FUNC_MOVE, 0, 0, 0, 40000);
    queue_item(FUNC_MOVE, 0, 0, 0, 1);
    drain();

    set_regs(16, 16, 14300, 42598, 6554);
    random_phase(100);
    set_regs(8, 8, 14300, 42598, 6554);
    random_phase(80);
    set_regs(3, 5, 0, 65536, 65536);
    random_phase(50);
    set_regs(1, 1, 65536, 0, 0);
    random_phase(20);
    set_regs(0, 0, 30000, 30000, 30000);
    random_phase(15);
    set_regs(127, 4, 131071, 131071, 131071);
    random_phase(50);
    set_regs(6, 10, 65536, 65536, 0);
    random_phase(50);
    set_regs(16, 16, $urandom_range(0, 65536), $urandom_range(0, 65536),
             $urandom_range(0, 65536));
    random_phase(80);
    set_regs(4, 127, 20000, 50000, 10000);
    random_phase(50);
    set_regs(4, 4, 1, 1, 1);
    random_phase(25);

    if (!failed) begin
      $display("pheromone_grid_walker_unit regression: pass");
    end else begin
      $display("pheromone_grid_walker_unit regression: fail");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #10000000;
    $display("pheromone_grid_walker_unit regression: fail");
    $finish;
  end

endmodule
